FILE: rtl/i2cmps_pkg.sv
// Shared types and codes for the I2C master phase sequencer.
package i2cmps_pkg;

  typedef enum logic [2:0] {
    CMD_NONE        = 3'd0,
    CMD_START       = 3'd1,
    CMD_STOP        = 3'd2,
    CMD_WRITE       = 3'd3,
    CMD_READ        = 3'd4,
    CMD_START_WRITE = 3'd5,
    CMD_START_READ  = 3'd6
  } cmd_e;

  // One bus delay interval with the command that may start in it.
  typedef struct packed {
    logic [2:0] command;
    logic [6:0] device_address;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_in;
  } item_t;

  // Line levels and status after one interval.
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] read_data;
    logic [7:0] bytes_left;
    logic       bus_active;
  } result_t;

endpackage

FILE: rtl/i2cmps_in_reg.sv
// Input register that holds one accepted interval until the core takes it.
module i2cmps_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  i2cmps_pkg::item_t   item_i,
  output logic                valid_o,
  input  logic                take_i,
  output i2cmps_pkg::item_t   item_o
);

  logic              valid_q;
  i2cmps_pkg::item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

FILE: rtl/i2cmps_core.sv
// Bus phase sequencer: state registers and the one-interval step logic.
module i2cmps_core #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  i2cmps_pkg::item_t     item_i,
  output i2cmps_pkg::result_t   result_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_RS, PH_SL, PH_CL, PH_W0, PH_W1, PH_W2,
    PH_R0, PH_R1, PH_A0, PH_A1, PH_A2, PH_S0, PH_S1
  } phase_e;

  localparam int LeftWidth = (COUNT_WIDTH < 8) ? COUNT_WIDTH : 8;

  phase_e                 phase_q, phase_d;
  i2cmps_pkg::cmd_e       cmd_q, cmd_d;
  logic [3:0]             bit_idx_q, bit_idx_d;
  logic [7:0]             shift_q, shift_d;
  logic                   bus_q, bus_d;
  logic [COUNT_WIDTH-1:0] bytes_q, bytes_d;
  logic                   ack_q, ack_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic                   drv_q, drv_d;

  always_comb begin
    phase_e     nxt;
    logic [3:0] inc;
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    bus_d     = bus_q;
    bytes_d   = bytes_q;
    ack_d     = ack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    drv_d     = drv_q;
    nxt       = PH_IDLE;
    inc       = bit_idx_q + 4'd1;
    result_o  = '0;

    // A command is taken only between commands; the first interval runs at once.
    if (phase_d == PH_IDLE) begin
      case (i2cmps_pkg::cmd_e'(item_i.command))
        i2cmps_pkg::CMD_START: begin
          cmd_d = i2cmps_pkg::CMD_START; bit_idx_d = 4'd0;
          phase_d = bus_q ? PH_RS : PH_SL;
        end
        i2cmps_pkg::CMD_STOP: begin
          cmd_d = i2cmps_pkg::CMD_STOP; bit_idx_d = 4'd0;
          phase_d = PH_S0;
        end
        i2cmps_pkg::CMD_WRITE: begin
          cmd_d = i2cmps_pkg::CMD_WRITE; bit_idx_d = 4'd0;
          shift_d = item_i.write_data;
          phase_d = PH_W0;
        end
        i2cmps_pkg::CMD_READ: begin
          cmd_d = i2cmps_pkg::CMD_READ; bit_idx_d = 4'd0;
          shift_d = 8'd0;
          phase_d = PH_R0;
        end
        i2cmps_pkg::CMD_START_WRITE: begin
          cmd_d = i2cmps_pkg::CMD_START_WRITE; bit_idx_d = 4'd0;
          shift_d = {item_i.device_address, 1'b0};
          phase_d = bus_q ? PH_RS : PH_SL;
        end
        i2cmps_pkg::CMD_START_READ: begin
          cmd_d = i2cmps_pkg::CMD_START_READ; bit_idx_d = 4'd0;
          shift_d = {item_i.device_address, 1'b1};
          bytes_d = COUNT_WIDTH'(item_i.read_count);
          phase_d = bus_q ? PH_RS : PH_SL;
        end
        default: ;
      endcase
    end

    if (phase_d != PH_IDLE) begin
      inc = bit_idx_d + 4'd1;
      case (phase_d)
        PH_RS: begin
          drv_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1; nxt = PH_SL;
        end
        PH_SL: begin
          drv_d = 1'b1; sda_d = 1'b0; nxt = PH_CL;
        end
        PH_CL: begin
          scl_d = 1'b0; bus_d = 1'b1;
          if (cmd_d == i2cmps_pkg::CMD_START) begin
            nxt = PH_IDLE;
          end else begin
            bit_idx_d = 4'd0; nxt = PH_W0;
          end
        end
        PH_W0: begin
          drv_d = 1'b1;
          sda_d = shift_d[3'd7 - bit_idx_d[2:0]];
          nxt = PH_W1;
        end
        PH_W1: begin
          scl_d = 1'b1; nxt = PH_W2;
        end
        PH_W2: begin
          scl_d = 1'b0;
          if (inc >= 4'd8) begin
            bit_idx_d = 4'd0; nxt = PH_R0;
          end else begin
            bit_idx_d = inc; nxt = PH_W0;
          end
        end
        PH_R0: begin
          drv_d = 1'b0; sda_d = 1'b1; scl_d = 1'b1;
          if (cmd_d == i2cmps_pkg::CMD_READ) begin
            shift_d = {shift_d[6:0], item_i.sda_in};
          end else begin
            ack_d = !item_i.sda_in;
          end
          nxt = PH_R1;
        end
        PH_R1: begin
          scl_d = 1'b0;
          if (cmd_d != i2cmps_pkg::CMD_READ) begin
            // A start read whose address was refused expects no bytes.
            if (cmd_d == i2cmps_pkg::CMD_START_READ && !ack_d) begin
              bytes_d = '0;
            end
            nxt = PH_IDLE;
          end else if (inc >= 4'd8) begin
            bit_idx_d = 4'd0; nxt = PH_A0;
          end else begin
            bit_idx_d = inc; nxt = PH_R0;
          end
        end
        PH_A0: begin
          drv_d = 1'b1;
          sda_d = (bytes_d > COUNT_WIDTH'(1)) ? 1'b0 : 1'b1;
          nxt = PH_A1;
        end
        PH_A1: begin
          scl_d = 1'b1; nxt = PH_A2;
        end
        PH_A2: begin
          scl_d = 1'b0;
          if (bytes_d > COUNT_WIDTH'(1)) begin
            bytes_d = bytes_d - COUNT_WIDTH'(1); nxt = PH_IDLE;
          end else begin
            nxt = PH_S0;
          end
        end
        PH_S0: begin
          drv_d = 1'b1; sda_d = 1'b0; scl_d = 1'b1; nxt = PH_S1;
        end
        PH_S1: begin
          sda_d = 1'b1; bus_d = 1'b0;
          if (cmd_d == i2cmps_pkg::CMD_READ) begin
            bytes_d = '0;
          end
          nxt = PH_IDLE;
        end
        default: nxt = PH_IDLE;
      endcase
      phase_d = nxt;
      if (phase_d == PH_IDLE) begin
        result_o.done_res = 1'b1;
        if (cmd_d == i2cmps_pkg::CMD_WRITE || cmd_d == i2cmps_pkg::CMD_START_WRITE ||
            cmd_d == i2cmps_pkg::CMD_START_READ) begin
          result_o.ack_ok = ack_d;
        end
        if (cmd_d == i2cmps_pkg::CMD_READ) begin
          result_o.read_data = shift_d;
        end
      end else begin
        result_o.busy_res = 1'b1;
      end
    end

    result_o.scl        = scl_d;
    result_o.sda_out    = sda_d;
    result_o.sda_drive  = drv_d;
    result_o.bytes_left = 8'(bytes_d[LeftWidth-1:0]);
    result_o.bus_active = bus_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cmd_q     <= i2cmps_pkg::CMD_NONE;
      bit_idx_q <= 4'd0;
      shift_q   <= 8'd0;
      bus_q     <= 1'b0;
      bytes_q   <= '0;
      ack_q     <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      drv_q     <= 1'b1;
    end else if (step_i) begin
      phase_q   <= phase_d;
      cmd_q     <= cmd_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      bus_q     <= bus_d;
      bytes_q   <= bytes_d;
      ack_q     <= ack_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      drv_q     <= drv_d;
    end
  end

endmodule

FILE: rtl/i2cmps_out_reg.sv
// Result register that holds one interval's outputs until the sink takes it.
module i2cmps_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  i2cmps_pkg::result_t   result_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output i2cmps_pkg::result_t   result_o
);

  logic                valid_q;
  i2cmps_pkg::result_t result_q;

  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

endmodule

FILE: rtl/i2c_master_phase_sequencer.sv
// Top level of the I2C master phase sequencer.
//
//   channel  dir  width          contents
//   s_axis   in   tdata 24, tuser 3   one bus delay interval and its command
//   m_axis   out  tdata 24       line levels and status after that interval
//
// One interval is accepted every cycle while the result side is not stalled; its result
// is held first in the input register and then in the result register.
// Reset leaves the sequencer idle with SCL and SDA driven high and no bus held.
// A stalled result holds; one more interval can wait in the input register,
// after which s_axis_tready drops until the result is taken.
module i2c_master_phase_sequencer #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] device_address, [14:7] write_data, [22:15] read_count, [23] sda_in
  input  logic [23:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res, [5] ack_ok,
  // [13:6] read_data, [21:14] bytes_left, [22] bus_active, [23] zero
  output logic [23:0] m_axis_tdata
);

  i2cmps_pkg::item_t   in_item, reg_item;
  i2cmps_pkg::result_t core_res, out_res;
  logic                reg_valid, out_ready, step;

  assign in_item.command        = s_axis_tuser;
  assign in_item.device_address = s_axis_tdata[6:0];
  assign in_item.write_data     = s_axis_tdata[14:7];
  assign in_item.read_count     = s_axis_tdata[22:15];
  assign in_item.sda_in         = s_axis_tdata[23];

  assign step = reg_valid && out_ready;

  i2cmps_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (reg_valid),
    .take_i  (step),
    .item_o  (reg_item)
  );

  i2cmps_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (reg_item),
    .result_o (core_res)
  );

  i2cmps_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (reg_valid),
    .ready_o  (out_ready),
    .result_i (core_res),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.bus_active, out_res.bytes_left, out_res.read_data,
                         out_res.ack_ok, out_res.done_res, out_res.busy_res,
                         out_res.sda_drive, out_res.sda_out, out_res.scl};

endmodule

FILE: rtl/i2cmps_checker.sv
// Port-level checks for the I2C master phase sequencer, bound to the top level.
module i2cmps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A held result must not change while the sink stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An interval either continues the command or ends it, never both.
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]))
    else $error("busy and done together");

  // Acknowledge status and received data are only reported when a command ends.
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[5] || m_axis_tdata[13:6] != 8'd0) |-> m_axis_tdata[4])
    else $error("ack or read data without done");

  // Input back-pressure only appears while a result is waiting.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

endmodule

bind i2c_master_phase_sequencer i2cmps_checker u_i2cmps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the I2C master phase sequencer stream block.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          LONG_STALL    = 300;
  localparam int          END_SETTLE    = 20;
  localparam logic [2:0]  CMD_UNDEFINED = 3'd7;

  // Bus phases of the sequencer as the predictor tracks them.
  typedef enum logic [4:0] {
    SP_IDLE, SP_REP_START, SP_SDA_LOW, SP_SCL_LOW,
    SP_BIT_SET, SP_BIT_HIGH, SP_BIT_LOW,
    SP_SAMPLE_HIGH, SP_SAMPLE_LOW,
    SP_ACK_SET, SP_ACK_HIGH, SP_ACK_LOW,
    SP_STOP_LOW, SP_STOP_HIGH
  } seq_phase_e;

  // How the simulated slave drives SDA during a command.
  typedef enum logic [1:0] {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [6:0] device_address, [14:7] write_data, [22:15] read_count, [23] sda_in
  logic [23:0] s_axis_tdata;
  // [2:0] command
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res, [5] ack_ok,
  // [13:6] read_data, [21:14] bytes_left, [22] bus_active, [23] zero
  logic [23:0] m_axis_tdata;

  // Predicted sequencer state.
  seq_phase_e        ph         = SP_IDLE;
  i2cmps_pkg::cmd_e  cur_cmd    = i2cmps_pkg::CMD_NONE;
  logic [3:0]        bit_cnt    = '0;
  logic [7:0]        shreg      = '0;
  logic              bus_held   = 1'b0;
  logic [7:0]        count_left = '0;
  logic              slave_ack  = 1'b0;
  logic              scl_q      = 1'b1;
  logic              sda_q      = 1'b1;
  logic              sda_en     = 1'b1;

  i2cmps_pkg::result_t pending_levels[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_reqs    = 0;
  int          stall_served  = 0;
  int          hold_left     = 0;
  int          errors        = 0;
  int          intervals_sent  = 0;
  int          results_checked = 0;
  int          commands_run    = 0;
  int          cycle_count     = 0;

  i2c_master_phase_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("i2c_master_phase_sequencer: mismatch");
      $finish;
    end
  end

  // Runs one interval of the current bus phase and returns the next one.
  function automatic seq_phase_e step_phase(logic sda_in);
    case (ph)
      SP_REP_START: begin
        sda_en = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
        return SP_SDA_LOW;
      end
      SP_SDA_LOW: begin
        sda_en = 1'b1; sda_q = 1'b0;
        return SP_SCL_LOW;
      end
      SP_SCL_LOW: begin
        scl_q = 1'b0;
        bus_held = 1'b1;
        if (cur_cmd == i2cmps_pkg::CMD_START) return SP_IDLE;
        bit_cnt = '0;
        return SP_BIT_SET;
      end
      SP_BIT_SET: begin
        sda_en = 1'b1;
        sda_q = shreg[3'd7 - bit_cnt[2:0]];
        return SP_BIT_HIGH;
      end
      SP_BIT_HIGH: begin
        scl_q = 1'b1;
        return SP_BIT_LOW;
      end
      SP_BIT_LOW: begin
        scl_q = 1'b0;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          bit_cnt = '0;
          return SP_SAMPLE_HIGH;
        end
        return SP_BIT_SET;
      end
      SP_SAMPLE_HIGH: begin
        sda_en = 1'b0; sda_q = 1'b1; scl_q = 1'b1;
        if (cur_cmd == i2cmps_pkg::CMD_READ) shreg = {shreg[6:0], sda_in};
        else slave_ack = ~sda_in;
        return SP_SAMPLE_LOW;
      end
      SP_SAMPLE_LOW: begin
        scl_q = 1'b0;
        if (cur_cmd != i2cmps_pkg::CMD_READ) begin
          // A NACKed read address leaves nothing to read.
          if (cur_cmd == i2cmps_pkg::CMD_START_READ && !slave_ack) count_left = '0;
          return SP_IDLE;
        end
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          bit_cnt = '0;
          return SP_ACK_SET;
        end
        return SP_SAMPLE_HIGH;
      end
      SP_ACK_SET: begin
        sda_en = 1'b1;
        sda_q = (count_left > 8'd1) ? 1'b0 : 1'b1;
        return SP_ACK_HIGH;
      end
      SP_ACK_HIGH: begin
        scl_q = 1'b1;
        return SP_ACK_LOW;
      end
      SP_ACK_LOW: begin
        scl_q = 1'b0;
        if (count_left > 8'd1) begin
          count_left = count_left - 8'd1;
          return SP_IDLE;
        end
        return SP_STOP_LOW;
      end
      SP_STOP_LOW: begin
        sda_en = 1'b1; sda_q = 1'b0; scl_q = 1'b1;
        return SP_STOP_HIGH;
      end
      SP_STOP_HIGH: begin
        sda_q = 1'b1;
        bus_held = 1'b0;
        if (cur_cmd == i2cmps_pkg::CMD_READ) count_left = '0;
        return SP_IDLE;
      end
      default: return SP_IDLE;
    endcase
  endfunction

  // Advances the predicted state by one interval and returns its line levels.
  function automatic i2cmps_pkg::result_t predict_interval(i2cmps_pkg::item_t it);
    i2cmps_pkg::result_t r;
    r = '0;
    if (ph == SP_IDLE && it.command >= i2cmps_pkg::CMD_START &&
        it.command <= i2cmps_pkg::CMD_START_READ) begin
      cur_cmd = i2cmps_pkg::cmd_e'(it.command);
      bit_cnt = '0;
      commands_run++;
      case (it.command)
        i2cmps_pkg::CMD_START: ph = bus_held ? SP_REP_START : SP_SDA_LOW;
        i2cmps_pkg::CMD_STOP:  ph = SP_STOP_LOW;
        i2cmps_pkg::CMD_WRITE: begin
          shreg = it.write_data;
          ph = SP_BIT_SET;
        end
        i2cmps_pkg::CMD_READ: begin
          shreg = '0;
          ph = SP_SAMPLE_HIGH;
        end
        i2cmps_pkg::CMD_START_WRITE: begin
          shreg = {it.device_address, 1'b0};
          ph = bus_held ? SP_REP_START : SP_SDA_LOW;
        end
        default: begin
          shreg = {it.device_address, 1'b1};
          count_left = it.read_count;
          ph = bus_held ? SP_REP_START : SP_SDA_LOW;
        end
      endcase
    end
    if (ph != SP_IDLE) begin
      ph = step_phase(it.sda_in);
      if (ph == SP_IDLE) begin
        r.done_res = 1'b1;
        if (cur_cmd == i2cmps_pkg::CMD_WRITE || cur_cmd == i2cmps_pkg::CMD_START_WRITE ||
            cur_cmd == i2cmps_pkg::CMD_START_READ)
          r.ack_ok = slave_ack;
        if (cur_cmd == i2cmps_pkg::CMD_READ) r.read_data = shreg;
      end else begin
        r.busy_res = 1'b1;
      end
    end
    r.scl        = scl_q;
    r.sda_out    = sda_q;
    r.sda_drive  = sda_en;
    r.bytes_left = count_left;
    r.bus_active = bus_held;
    return r;
  endfunction

  // SDA level the slave shows in the interval the predictor is about to run.
  function automatic logic pick_sda(sda_mode_e mode);
    if (mode == SDA_LOW) return 1'b0;
    if (mode == SDA_HIGH) return 1'b1;
    if (ph == SP_SAMPLE_HIGH && cur_cmd != i2cmps_pkg::CMD_READ)
      return ($urandom_range(9) == 0);
    return 1'($urandom_range(1));
  endfunction

  // Offers one interval until the transaction completes and records its prediction.
  task automatic drive_interval(input i2cmps_pkg::item_t it,
                                output i2cmps_pkg::result_t pred);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.sda_in, it.read_count, it.write_data, it.device_address};
    s_axis_tuser  <= it.command;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_interval(it);
    pending_levels.push_back(pred);
    intervals_sent++;
  endtask

  // Issues one command and keeps the intervals coming until it is done.
  task automatic run_command(input logic [2:0] cmd, input logic [6:0] addr,
                             input logic [7:0] wdata, input logic [7:0] rcount,
                             input sda_mode_e mode);
    i2cmps_pkg::item_t   it;
    i2cmps_pkg::result_t r;
    it.command        = cmd;
    it.device_address = addr;
    it.write_data     = wdata;
    it.read_count     = rcount;
    it.sda_in         = pick_sda(mode);
    drive_interval(it, r);
    while (r.busy_res) begin
      // Commands offered while busy must be ignored.
      it.command        = 3'($urandom_range(7));
      it.device_address = 7'($urandom_range(127));
      it.write_data     = 8'($urandom_range(255));
      it.read_count     = 8'($urandom_range(255));
      it.sda_in         = pick_sda(mode);
      drive_interval(it, r);
    end
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random_transaction();
    int unsigned pick;
    int unsigned n;
    logic [6:0]  addr;
    logic [7:0]  rc;
    pick = $urandom_range(99);
    addr = 7'($urandom_range(127));
    if (pick < 35) begin
      run_command(i2cmps_pkg::CMD_START_WRITE, addr, 8'($urandom_range(255)),
                  8'($urandom_range(255)), SDA_RANDOM);
      n = $urandom_range(3);
      repeat (n)
        run_command(i2cmps_pkg::CMD_WRITE, 7'($urandom_range(127)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), SDA_RANDOM);
      if ($urandom_range(3) != 0)
        run_command(i2cmps_pkg::CMD_STOP, addr, 8'($urandom_range(255)),
                    8'($urandom_range(255)), SDA_RANDOM);
    end else if (pick < 70) begin
      if ($urandom_range(1) != 0) begin
        run_command(i2cmps_pkg::CMD_START_WRITE, addr, 8'($urandom_range(255)),
                    8'($urandom_range(255)), SDA_RANDOM);
        run_command(i2cmps_pkg::CMD_WRITE, addr, 8'($urandom_range(255)),
                    8'($urandom_range(255)), SDA_RANDOM);
      end
      rc = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 4));
      run_command(i2cmps_pkg::CMD_START_READ, addr, 8'($urandom_range(255)), rc, SDA_RANDOM);
      n = 0;
      while (count_left != 0 && bus_held && n < 5) begin
        run_command(i2cmps_pkg::CMD_READ, addr, 8'($urandom_range(255)),
                    8'($urandom_range(255)), SDA_RANDOM);
        n++;
      end
      if (bus_held && $urandom_range(4) != 0)
        run_command(i2cmps_pkg::CMD_STOP, addr, 8'($urandom_range(255)),
                    8'($urandom_range(255)), SDA_RANDOM);
    end else if (pick < 80) begin
      run_command(i2cmps_pkg::CMD_START, addr, 8'($urandom_range(255)),
                  8'($urandom_range(255)), SDA_RANDOM);
      if ($urandom_range(1) != 0)
        run_command(i2cmps_pkg::CMD_START, addr, 8'($urandom_range(255)),
                    8'($urandom_range(255)), SDA_RANDOM);
      run_command(i2cmps_pkg::CMD_STOP, addr, 8'($urandom_range(255)),
                  8'($urandom_range(255)), SDA_RANDOM);
    end else if (pick < 90) begin
      n = $urandom_range(1, 6);
      repeat (n)
        run_command(($urandom_range(1) != 0) ? 3'(i2cmps_pkg::CMD_NONE) : CMD_UNDEFINED,
                    7'($urandom_range(127)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), SDA_RANDOM);
    end else begin
      // Stray commands in any bus state, with any slave behavior.
      run_command(3'($urandom_range(7)), addr, 8'($urandom_range(255)),
                  8'($urandom_range(255)), sda_mode_e'($urandom_range(2)));
    end
  endtask

  task automatic test_idle_intervals();
    run_command(i2cmps_pkg::CMD_NONE, 7'h00, 8'h00, 8'h00, SDA_LOW);
    run_command(i2cmps_pkg::CMD_NONE, 7'h7f, 8'hff, 8'hff, SDA_HIGH);
    run_command(CMD_UNDEFINED, 7'h7f, 8'hff, 8'hff, SDA_HIGH);
  endtask

  task automatic test_start_stop();
    run_command(i2cmps_pkg::CMD_START, 7'h00, 8'h00, 8'h00, SDA_LOW);
    run_command(i2cmps_pkg::CMD_START, 7'h00, 8'h00, 8'h00, SDA_LOW);
    run_command(i2cmps_pkg::CMD_STOP, 7'h00, 8'h00, 8'h00, SDA_LOW);
    run_command(i2cmps_pkg::CMD_STOP, 7'h00, 8'h00, 8'h00, SDA_HIGH);
  endtask

  task automatic test_write_bytes();
    run_command(i2cmps_pkg::CMD_START_WRITE, 7'h7f, 8'h00, 8'h00, SDA_LOW);
    run_command(i2cmps_pkg::CMD_WRITE, 7'h00, 8'hff, 8'h00, SDA_LOW);
    run_command(i2cmps_pkg::CMD_WRITE, 7'h00, 8'h00, 8'h00, SDA_HIGH);
    run_command(i2cmps_pkg::CMD_WRITE, 7'h00, 8'ha5, 8'h00, SDA_RANDOM);
    run_command(i2cmps_pkg::CMD_STOP, 7'h00, 8'h00, 8'h00, SDA_LOW);
    run_command(i2cmps_pkg::CMD_WRITE, 7'h00, 8'h3c, 8'h00, SDA_LOW);
    run_command(i2cmps_pkg::CMD_START_WRITE, 7'h00, 8'h00, 8'h00, SDA_HIGH);
    run_command(i2cmps_pkg::CMD_STOP, 7'h00, 8'h00, 8'h00, SDA_LOW);
  endtask

  task automatic test_read_bytes();
    // Address NACK clears the byte count.
    run_command(i2cmps_pkg::CMD_START_READ, 7'h00, 8'h00, 8'hff, SDA_HIGH);
    run_command(i2cmps_pkg::CMD_STOP, 7'h00, 8'h00, 8'h00, SDA_LOW);
    run_command(i2cmps_pkg::CMD_START_READ, 7'h55, 8'h00, 8'hff, SDA_LOW);
    run_command(i2cmps_pkg::CMD_READ, 7'h00, 8'h00, 8'h00, SDA_LOW);
    run_command(i2cmps_pkg::CMD_READ, 7'h00, 8'h00, 8'h00, SDA_HIGH);
    run_command(i2cmps_pkg::CMD_STOP, 7'h00, 8'h00, 8'h00, SDA_LOW);
    // The last byte of a read gets NACK and an automatic stop.
    run_command(i2cmps_pkg::CMD_START_READ, 7'h2a, 8'h00, 8'h02, SDA_LOW);
    run_command(i2cmps_pkg::CMD_READ, 7'h00, 8'h00, 8'h00, SDA_RANDOM);
    run_command(i2cmps_pkg::CMD_READ, 7'h00, 8'h00, 8'h00, SDA_RANDOM);
    run_command(i2cmps_pkg::CMD_READ, 7'h00, 8'h00, 8'h00, SDA_RANDOM);
    run_command(i2cmps_pkg::CMD_START_READ, 7'h11, 8'h00, 8'h00, SDA_LOW);
    run_command(i2cmps_pkg::CMD_READ, 7'h00, 8'h00, 8'h00, SDA_HIGH);
    run_command(i2cmps_pkg::CMD_START_READ, 7'h11, 8'h00, 8'h01, SDA_LOW);
    run_command(i2cmps_pkg::CMD_READ, 7'h00, 8'h00, 8'h00, SDA_RANDOM);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_items);
    int target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = intervals_sent + n_items;
    while (intervals_sent < target) run_random_transaction();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_stall();
    int target;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_reqs++;
    target = intervals_sent + 60;
    while (intervals_sent < target) run_random_transaction();
  endtask

  task automatic test_drain_pause();
    run_random_transaction();
    wait_for_drain();
    run_random_transaction();
  endtask

  always @(posedge clk_i) begin
    if (stall_reqs != stall_served) begin
      hold_left = LONG_STALL;
      stall_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    i2cmps_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_levels.size() == 0) begin
        $error("result with no interval outstanding: tdata 0x%0h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        compare_field("scl", want.scl, m_axis_tdata[0]);
        compare_field("sda_out", want.sda_out, m_axis_tdata[1]);
        compare_field("sda_drive", want.sda_drive, m_axis_tdata[2]);
        compare_field("busy_res", want.busy_res, m_axis_tdata[3]);
        compare_field("done_res", want.done_res, m_axis_tdata[4]);
        compare_field("ack_ok", want.ack_ok, m_axis_tdata[5]);
        compare_field("read_data", want.read_data, m_axis_tdata[13:6]);
        compare_field("bytes_left", want.bytes_left, m_axis_tdata[21:14]);
        compare_field("bus_active", want.bus_active, m_axis_tdata[22]);
        compare_field("pad", 0, m_axis_tdata[23]);
        results_checked++;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = i2cmps_pkg::CMD_NONE;
    m_axis_tready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_intervals();
    test_start_stop();
    test_write_bytes();
    test_read_bytes();
    test_random_traffic(24, 86, 80);
    test_output_stall();
    test_drain_pause();
    test_random_traffic(86, 24, 80);
    test_random_traffic(0, 0, 80);

    wait_for_drain();
    repeat (END_SETTLE) @(posedge clk_i);

    $display("Drove %0d bus intervals carrying %0d commands under input and output stalls,",
             intervals_sent, commands_run);
    $display("including a long output hold-off and a full drain; %0d results compared.",
             results_checked);
    if (errors == 0) begin
      $display("i2c_master_phase_sequencer: match");
    end else begin
      $display("i2c_master_phase_sequencer: mismatch");
    end
    $finish;
  end

endmodule
